// ===== rtl/fbrf_pkg.sv =====
// Package for the framebuffer rectangle fill and scanout block.
// Holds default screen size, opcodes and the controller/datapath interface types.
// No dependencies.
package fbrf_pkg;

  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 128;

  localparam int DIM_W   = 9;
  localparam int COORD_W = 8;
  localparam int PIXEL_W = 16;
  localparam int BYTE_W  = 8;

  localparam logic [PIXEL_W-1:0] BYTE_MASK = 16'h00FF;

  localparam logic OP_FILL = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  typedef struct packed {
    logic clr_write;
    logic capture;
    logic fill_setup;
    logic fill_step;
    logic scan_read;
    logic sel_lo;
  } fbrf_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic fill_empty;
    logic fill_last;
  } fbrf_status_t;

endpackage

// ===== rtl/fbrf_ctrl.sv =====
// Controller state machine for the framebuffer block.
// Sequences clear, fill walk and two-byte scanout; depends on fbrf_pkg.
module fbrf_ctrl
  import fbrf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_opcode,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  fbrf_status_t status,
  output fbrf_cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FSET  = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_HI    = 3'd5;
  localparam logic [2:0] S_LO    = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       in_accept;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_HI) || (state_r == S_LO);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.sel_lo     = (state_r == S_LO);
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_opcode == OP_SCAN) ? S_READ : S_FSET;
        end
      end
      S_FSET: begin
        cmd.fill_setup = 1'b1;
        state_nxt      = S_FILL;
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_empty || status.fill_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        cmd.scan_read = 1'b1;
        state_nxt     = S_HI;
      end
      S_HI: begin
        if (!out_stall) begin
          state_nxt = S_LO;
        end
      end
      S_LO: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/fbrf_dpath.sv =====
// Datapath for the framebuffer block: pixel memory, fill walker, scan pointer.
// Driven by fbrf_ctrl commands; depends on fbrf_pkg.
module fbrf_dpath
  import fbrf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fbrf_cmd_t          cmd,
  output fbrf_status_t       status,
  input  logic [COORD_W-1:0] in_rect_x,
  input  logic [COORD_W-1:0] in_rect_y,
  input  logic [COORD_W-1:0] in_rect_w,
  input  logic [COORD_W-1:0] in_rect_h,
  input  logic [PIXEL_W-1:0] in_fill_color,
  output logic [BYTE_W-1:0]  out_pixel_byte,
  output logic               out_frame_end,
  output logic               out_pair_last
);

  localparam int FRAME_PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW           = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int START_W      = COORD_W + DIM_W;

  localparam logic [AW-1:0]    LAST_PIX = AW'(FRAME_PIXELS - 1);
  localparam logic [AW-1:0]    ROW_STEP = AW'(SCREEN_WIDTH);
  localparam logic [DIM_W-1:0] SW       = DIM_W'(SCREEN_WIDTH);
  localparam logic [DIM_W-1:0] SH       = DIM_W'(SCREEN_HEIGHT);

  logic [PIXEL_W-1:0] mem [FRAME_PIXELS];

  logic [COORD_W-1:0] x_r, y_r, w_r, h_r;
  logic [PIXEL_W-1:0] color_r;
  logic [DIM_W-1:0]   rows_r, cols_r, row_cnt_r, col_cnt_r;
  logic [AW-1:0]      base_r;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [PIXEL_W-1:0] rd_data_r;
  logic               last_r;

  logic               off_screen;
  logic [DIM_W-1:0]   rows_room, cols_room, rows_clip, cols_clip;
  logic [START_W-1:0] start_full;
  logic [AW-1:0]      start_addr;
  logic               col_end, row_end;
  logic               mem_we;
  logic [PIXEL_W-1:0] mem_wdata;

  assign off_screen = ({1'b0, x_r} >= SW) || ({1'b0, y_r} >= SH);
  assign rows_room  = SH - {1'b0, y_r};
  assign cols_room  = SW - {1'b0, x_r};
  assign rows_clip  = ({1'b0, h_r} < rows_room) ? {1'b0, h_r} : rows_room;
  assign cols_clip  = ({1'b0, w_r} < cols_room) ? {1'b0, w_r} : cols_room;
  assign start_full = START_W'(y_r) * START_W'(SW) + START_W'(x_r);
  assign start_addr = start_full[AW-1:0];

  assign col_end = ((col_cnt_r + DIM_W'(1)) == cols_r);
  assign row_end = ((row_cnt_r + DIM_W'(1)) == rows_r);

  assign status.clr_last   = (addr_r == LAST_PIX);
  assign status.fill_empty = (rows_r == '0) || (cols_r == '0);
  assign status.fill_last  = col_end && row_end;

  assign mem_we    = cmd.clr_write || (cmd.fill_step && !status.fill_empty);
  assign mem_wdata = cmd.clr_write ? '0 : color_r;

  always_comb begin
    addr_nxt = addr_r;
    if (cmd.clr_write) begin
      addr_nxt = addr_r + AW'(1);
    end else if (cmd.fill_setup) begin
      addr_nxt = start_addr;
    end else if (cmd.fill_step) begin
      addr_nxt = col_end ? (base_r + ROW_STEP) : (addr_r + AW'(1));
    end
  end

  assign ptr_nxt = (ptr_r == LAST_PIX) ? '0 : (ptr_r + AW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      ptr_r  <= '0;
    end else begin
      addr_r <= addr_nxt;
      if (cmd.scan_read) begin
        ptr_r <= ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r     <= in_rect_x;
      y_r     <= in_rect_y;
      w_r     <= in_rect_w;
      h_r     <= in_rect_h;
      color_r <= in_fill_color;
    end
    if (cmd.fill_setup) begin
      rows_r    <= off_screen ? '0 : rows_clip;
      cols_r    <= off_screen ? '0 : cols_clip;
      base_r    <= start_addr;
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else if (cmd.fill_step) begin
      if (col_end) begin
        col_cnt_r <= '0;
        row_cnt_r <= row_cnt_r + DIM_W'(1);
        base_r    <= base_r + ROW_STEP;
      end else begin
        col_cnt_r <= col_cnt_r + DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= mem_wdata;
    end
    if (cmd.scan_read) begin
      rd_data_r <= mem[ptr_r];
      last_r    <= (ptr_r == LAST_PIX);
    end
  end

  assign out_pixel_byte = cmd.sel_lo ? BYTE_W'(rd_data_r & BYTE_MASK)
                                     : BYTE_W'((rd_data_r >> BYTE_W) & BYTE_MASK);
  assign out_frame_end  = cmd.sel_lo && last_r;
  assign out_pair_last  = cmd.sel_lo;

endmodule

// ===== rtl/framebuffer_rect_fill_and_scanout.sv =====
// Top level of the RGB565 framebuffer with rectangle fill and raster scanout.
// Joins fbrf_ctrl and fbrf_dpath; depends on fbrf_pkg.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | opcode, rect_x/y/w/h, fill_color
//   out_    | output    | out_valid/out_stall | pixel_byte, frame_end, pair_last
//
// After reset the pixel memory is cleared one entry per cycle, all SCREEN_WIDTH *
// SCREEN_HEIGHT entries, with in_stall high.
// A scan: accept, memory read, high byte, low byte; out_stall holds either byte.
// A fill: accept, setup, then a walk of the clipped rows * cols; the single memory
// write port writes one pixel per cycle. One transaction is in flight at a time.
module framebuffer_rect_fill_and_scanout
  import fbrf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [COORD_W-1:0] in_rect_x,
  input  logic [COORD_W-1:0] in_rect_y,
  input  logic [COORD_W-1:0] in_rect_w,
  input  logic [COORD_W-1:0] in_rect_h,
  input  logic [PIXEL_W-1:0] in_fill_color,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BYTE_W-1:0]  out_pixel_byte,
  output logic               out_frame_end,
  output logic               out_pair_last
);

  fbrf_cmd_t    cmd;
  fbrf_status_t status;

  fbrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  fbrf_dpath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_rect_x      (in_rect_x),
    .in_rect_y      (in_rect_y),
    .in_rect_w      (in_rect_w),
    .in_rect_h      (in_rect_h),
    .in_fill_color  (in_fill_color),
    .out_pixel_byte (out_pixel_byte),
    .out_frame_end  (out_frame_end),
    .out_pair_last  (out_pair_last)
  );

endmodule

// ===== rtl/fbrf_checker.sv =====
// Port-level checker for framebuffer_rect_fill_and_scanout, bound to the top level.
// Depends on fbrf_pkg.
module fbrf_checker
  import fbrf_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] out_pixel_byte,
  input logic              out_frame_end,
  input logic              out_pair_last
);

  a_hi_then_lo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_pair_last |=> out_valid && out_pair_last)
    else $error("high byte not followed by low byte");

  a_end_on_lo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_pair_last)
    else $error("frame end on high byte");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  a_byte_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_pixel_byte))
    else $error("unknown scan byte");

endmodule

bind framebuffer_rect_fill_and_scanout fbrf_checker u_fbrf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_pixel_byte (out_pixel_byte),
  .out_frame_end  (out_frame_end),
  .out_pair_last  (out_pair_last)
);

// ===== tb/tb.sv =====
// Self-checking testbench for framebuffer_rect_fill_and_scanout: rectangle fills and raster scans
// are mirrored in a shadow framebuffer, and every scanout byte is compared in order.
// Depends on fbrf_pkg and the framebuffer_rect_fill_and_scanout RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbrf_pkg::*;

  localparam int SCR_W        = DEF_SCREEN_WIDTH;
  localparam int SCR_H        = DEF_SCREEN_HEIGHT;
  localparam int FRAME_PIXELS = SCR_W * SCR_H;
  localparam int RAND_ITEMS   = 1250;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              frame_end;
    logic              pair_last;
  } scan_byte_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_opcode = OP_FILL;
  logic [COORD_W-1:0] in_rect_x = '0;
  logic [COORD_W-1:0] in_rect_y = '0;
  logic [COORD_W-1:0] in_rect_w = '0;
  logic [COORD_W-1:0] in_rect_h = '0;
  logic [PIXEL_W-1:0] in_fill_color = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [BYTE_W-1:0]  out_pixel_byte;
  logic               out_frame_end;
  logic               out_pair_last;

  logic [PIXEL_W-1:0] pixel_shadow [FRAME_PIXELS];
  int                 scan_index = 0;
  scan_byte_t         pending_bytes [$];
  int                 mismatches = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;

  framebuffer_rect_fill_and_scanout uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_rect_x     (in_rect_x),
    .in_rect_y     (in_rect_y),
    .in_rect_w     (in_rect_w),
    .in_rect_h     (in_rect_h),
    .in_fill_color (in_fill_color),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_byte(out_pixel_byte),
    .out_frame_end (out_frame_end),
    .out_pair_last (out_pair_last)
  );

  always begin
    #10;
    clk = 1'b1;
    #10;
    clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic void apply_fill(int x, int y, int w, int h, logic [PIXEL_W-1:0] color);
    int rows;
    int cols;
    if (x >= SCR_W || y >= SCR_H) return;
    rows = (h < SCR_H - y) ? h : SCR_H - y;
    cols = (w < SCR_W - x) ? w : SCR_W - x;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        pixel_shadow[(y + r) * SCR_W + x + c] = color;
      end
    end
  endfunction

  function automatic void predict_scan();
    logic [PIXEL_W-1:0] pix;
    logic               last;
    pix  = pixel_shadow[scan_index];
    last = (scan_index == FRAME_PIXELS - 1);
    pending_bytes.push_back('{data: pix[15:8], frame_end: 1'b0, pair_last: 1'b0});
    pending_bytes.push_back('{data: pix[7:0], frame_end: last, pair_last: 1'b1});
    scan_index = last ? 0 : scan_index + 1;
  endfunction

  task automatic send_txn(input logic op, input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                          input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                          input logic [PIXEL_W-1:0] color);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_rect_x     <= x;
    in_rect_y     <= y;
    in_rect_w     <= w;
    in_rect_h     <= h;
    in_fill_color <= color;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_SCAN) predict_scan();
    else apply_fill(x, y, w, h, color);
  endtask

  task automatic send_scan();
    send_txn(OP_SCAN, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic test_reset_clear();
    send_txn(OP_SCAN, '1, '1, '1, '1, '1);
  endtask

  task automatic test_fill_clipping();
    send_txn(OP_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 16'hFFFF);
    send_txn(OP_SCAN, '0, '0, '0, '0, '0);
    send_txn(OP_FILL, 8'd128, 8'd0, 8'd10, 8'd10, 16'h0000);
    send_txn(OP_FILL, 8'd0, 8'd128, 8'd10, 8'd10, 16'h0000);
    send_txn(OP_FILL, 8'd255, 8'd255, 8'd255, 8'd255, 16'h0000);
    send_scan();
    send_txn(OP_FILL, 8'd0, 8'd0, 8'd0, 8'd5, 16'h1234);
    send_txn(OP_FILL, 8'd0, 8'd0, 8'd5, 8'd0, 16'h1234);
    send_scan();
    send_txn(OP_FILL, 8'd4, 8'd0, 8'd1, 8'd1, 16'h0000);
    send_scan();
    send_txn(OP_FILL, 8'd5, 8'd0, 8'd255, 8'd1, 16'hA55A);
    send_txn(OP_FILL, 8'd127, 8'd0, 8'd255, 8'd255, 16'h8001);
    send_txn(OP_FILL, 8'd0, 8'd127, 8'd255, 8'd255, 16'h5AA5);
    send_txn(OP_FILL, 8'd126, 8'd126, 8'd1, 8'd1, 16'h7E7E);
    send_scan();
    send_scan();
  endtask

  task automatic test_random_mix(input int n_items, input int s_pct, input int r_pct);
    int                 mode;
    int                 row;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [PIXEL_W-1:0] color;
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 55) begin
        send_scan();
        continue;
      end
      row  = scan_index / SCR_W;
      mode = $urandom_range(99);
      x = 8'($urandom_range(SCR_W - 1));
      y = 8'(row + $urandom_range(2));
      w = 8'($urandom_range(24));
      h = 8'($urandom_range(3));
      if (mode < 2) begin
        x = 8'($urandom);
        y = 8'($urandom);
        w = 8'($urandom);
        h = 8'($urandom);
      end else if (mode < 12) begin
        x = 8'($urandom);
        y = 8'($urandom);
        w = 8'($urandom_range(15));
        h = 8'($urandom_range(15));
      end else if (mode < 24) begin
        w = 8'($urandom);
        h = 8'($urandom_range(2));
      end else if (mode < 36) begin
        y = 8'($urandom);
        w = 8'($urandom_range(2));
        h = 8'($urandom);
      end
      case ($urandom_range(9))
        0: color = 16'h0000;
        1: color = 16'hFFFF;
        default: color = 16'($urandom);
      endcase
      send_txn(OP_FILL, x, y, w, h, color);
    end
  endtask

  always @(posedge clk) begin : check_output
    scan_byte_t exp_b;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected scan byte %h", out_pixel_byte);
      end else begin
        exp_b = pending_bytes.pop_front();
        if (out_pixel_byte !== exp_b.data || out_frame_end !== exp_b.frame_end ||
            out_pair_last !== exp_b.pair_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("scan byte mismatch: expected %h end %b last %b, got %h end %b last %b",
                     exp_b.data, exp_b.frame_end, exp_b.pair_last,
                     out_pixel_byte, out_frame_end, out_pair_last);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < FRAME_PIXELS; i++) pixel_shadow[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct  = 26;
    recv_stall_pct = 54;
    test_reset_clear();
    test_fill_clipping();
    test_random_mix(RAND_ITEMS / 3, 26, 54);
    test_random_mix(RAND_ITEMS / 3, 54, 26);
    test_random_mix(RAND_ITEMS - 2 * (RAND_ITEMS / 3), 0, 0);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("** framebuffer_rect_fill_and_scanout: PASSED **");
    end else begin
      $display("** framebuffer_rect_fill_and_scanout: FAILED **");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("** framebuffer_rect_fill_and_scanout: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fbrf_pkg.sv
rtl/fbrf_ctrl.sv
rtl/fbrf_dpath.sv
rtl/framebuffer_rect_fill_and_scanout.sv
rtl/fbrf_checker.sv
tb/tb.sv
